// File: rtl/seacc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seacc_pkg
// Shared types and constants of the edge statistic accumulator.
// ----------------------------------------------------------------------------
package seacc_pkg;

  localparam int NODE_COUNT = 128;
  localparam int NODE_W     = 7;
  localparam int EDGE_DEPTH = NODE_COUNT * (NODE_COUNT + 1) / 2;
  localparam int IDX_W      = $clog2(EDGE_DEPTH);
  localparam int VAL_W      = 48;
  localparam int DIV_N_W    = 64;
  localparam int DIV_CNT_W  = $clog2(DIV_N_W);

  localparam logic [1:0] STAT_SUM  = 2'd0;
  localparam logic [1:0] STAT_MEAN = 2'd1;
  localparam logic [1:0] STAT_MIN  = 2'd2;
  localparam logic [1:0] STAT_MAX  = 2'd3;

  localparam logic OP_ACC  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] REG_STAT_MODE   = 2'd0;
  localparam logic [1:0] REG_VECTOR_MODE = 2'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] edge_val;
    logic [VAL_W-1:0]        weight;
    logic                    touched;
    logic                    sat;
  } entry_t;

  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic wr_en;
    logic div_start;
    logic out_load;
    logic clr_en;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_read;
    logic need_div;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// File: rtl/seacc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seacc_div
// Restoring divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module seacc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [seacc_pkg::DIV_N_W-1:0]     num,
  input  logic [seacc_pkg::VAL_W-1:0]       den,
  output logic [seacc_pkg::DIV_N_W-1:0]     quo,
  output logic                              done
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [seacc_pkg::DIV_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [seacc_pkg::VAL_W-1:0]         rem_r, rem_nxt;
  logic [seacc_pkg::DIV_N_W-1:0]       quo_r, quo_nxt;
  logic [seacc_pkg::VAL_W-1:0]         den_r, den_nxt;
  logic [seacc_pkg::VAL_W:0]           rem_sh;
  logic [seacc_pkg::VAL_W:0]           trial;

  // shift in one dividend bit and try a subtract
  always_comb begin
    rem_sh   = {rem_r, quo_r[seacc_pkg::DIV_N_W-1]};
    trial    = rem_sh - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
    end else if (busy_r) begin
      if (!trial[seacc_pkg::VAL_W]) begin
        rem_nxt = trial[seacc_pkg::VAL_W-1:0];
        quo_nxt = {quo_r[seacc_pkg::DIV_N_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[seacc_pkg::VAL_W-1:0];
        quo_nxt = {quo_r[seacc_pkg::DIV_N_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (&cnt_r) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

// File: rtl/seacc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seacc_ctrl
// Sequencer: table clear, read-modify-write, and edge read (with divide for a mean).
// ----------------------------------------------------------------------------
module seacc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  seacc_pkg::status_t  sts,
  output seacc_pkg::cmd_t     cmd
);

  seacc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= seacc_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      seacc_pkg::ST_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (sts.clr_last) state_nxt = seacc_pkg::ST_IDLE;
      end
      seacc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = seacc_pkg::ST_READ;
        end
      end
      seacc_pkg::ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = seacc_pkg::ST_EXEC;
      end
      seacc_pkg::ST_EXEC: begin
        if (!sts.op_read) begin
          cmd.wr_en = 1'b1;
          state_nxt = seacc_pkg::ST_IDLE;
        end else if (sts.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt     = seacc_pkg::ST_DIV;
        end else begin
          state_nxt = seacc_pkg::ST_OUT;
        end
      end
      seacc_pkg::ST_DIV: begin
        if (sts.div_done) state_nxt = seacc_pkg::ST_OUT;
      end
      seacc_pkg::ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = seacc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = seacc_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: rtl/seacc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seacc_dp
// Datapath: edge table, index math, multiply, update and finalize.
// ----------------------------------------------------------------------------
module seacc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  seacc_pkg::cmd_t                      cmd,
  output seacc_pkg::status_t                   sts,
  input  logic                                 cfg_we,
  input  logic [1:0]                           cfg_index,
  input  logic [1:0]                           cfg_wdata,
  input  logic                                 in_opcode,
  input  logic [seacc_pkg::NODE_W-1:0]         in_node_a,
  input  logic [seacc_pkg::NODE_W-1:0]         in_node_b,
  input  logic signed [31:0]                   in_sample_value,
  input  logic [31:0]                          in_sample_weight,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [seacc_pkg::VAL_W-1:0]   out_edge_value,
  output logic                                 out_edge_empty,
  output logic                                 out_sum_saturated
);

  localparam int VW = seacc_pkg::VAL_W;
  localparam int IW = seacc_pkg::IDX_W;
  localparam int MW = 2 * (IW + 1);

  // configuration
  logic [1:0] stat_mode_r;
  logic       vector_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_mode_r   <= seacc_pkg::STAT_SUM;
      vector_mode_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == seacc_pkg::REG_STAT_MODE) stat_mode_r <= cfg_wdata;
      if (cfg_index == seacc_pkg::REG_VECTOR_MODE) vector_mode_r <= cfg_wdata[0];
    end
  end

  // edge index of the incoming word
  logic [seacc_pkg::NODE_W-1:0] lo, hi;
  logic [IW:0]                  lo_x, span_x;
  logic [MW-1:0]                tri_prod;
  logic [IW-1:0]                idx_calc;
  logic                         ok_calc;

  always_comb begin
    lo       = (in_node_a < in_node_b) ? in_node_a : in_node_b;
    hi       = (in_node_a < in_node_b) ? in_node_b : in_node_a;
    lo_x     = (IW + 1)'(lo);
    span_x   = (IW + 1)'(2 * seacc_pkg::NODE_COUNT + 1) - lo_x;
    tri_prod = MW'(lo_x) * MW'(span_x);
    ok_calc  = (32'(in_node_a) < 32'(seacc_pkg::NODE_COUNT)) &&
               (32'(in_node_b) < 32'(seacc_pkg::NODE_COUNT));
    if (vector_mode_r) begin
      idx_calc = IW'(in_node_b);
    end else begin
      idx_calc = IW'(tri_prod >> 1) + IW'(hi - lo);
    end
  end

  // capture the accepted word
  logic              op_r, ok_r;
  logic [IW-1:0]     idx_r;
  logic [31:0]       v_r, w_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_opcode;
      ok_r  <= ok_calc;
      idx_r <= idx_calc;
      v_r   <= in_sample_value;
      w_r   <= in_sample_weight;
    end
  end

  // edge table with clear sweep
  seacc_pkg::entry_t mem [seacc_pkg::EDGE_DEPTH];
  seacc_pkg::entry_t rd_r, wr_entry;
  logic [IW-1:0]     clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_en) begin
      mem[clr_cnt_r] <= '0;
    end else if (cmd.wr_en && ok_r) begin
      mem[idx_r] <= wr_entry;
    end
    if (cmd.rd_en) rd_r <= mem[idx_r];
  end

  // magnitude product, registered
  logic        v_neg;
  logic [31:0] v_mag;
  logic [63:0] prod_r;

  assign v_neg = v_r[31];
  assign v_mag = v_neg ? (32'd0 - v_r) : v_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) prod_r <= 64'(v_mag) * 64'(w_r);
  end

  // entry update
  logic [63:0]              prod_rnd;
  logic [VW-1:0]            r_mag;
  logic signed [VW+1:0]     term, sum_w;
  logic signed [VW-1:0]     sum_sat, v_ext;
  logic                     sum_ovf;
  logic [VW:0]              wsum;
  logic                     w_ovf;

  always_comb begin
    prod_rnd = prod_r + 64'h8000;
    r_mag    = prod_rnd[VW+15:16];
    term     = v_neg ? -$signed({2'b00, r_mag}) : $signed({2'b00, r_mag});
    sum_w    = $signed({{2{rd_r.edge_val[VW-1]}}, rd_r.edge_val}) + term;
    sum_ovf  = !((sum_w[VW+1] == sum_w[VW]) && (sum_w[VW] == sum_w[VW-1]));
    if (!sum_ovf) begin
      sum_sat = sum_w[VW-1:0];
    end else if (sum_w[VW+1]) begin
      sum_sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(VW-1){1'b1}}};
    end
    wsum  = {1'b0, rd_r.weight} + (VW + 1)'(w_r);
    w_ovf = wsum[VW];
    v_ext = VW'($signed(v_r));

    wr_entry         = rd_r;
    wr_entry.touched = 1'b1;
    if (stat_mode_r == seacc_pkg::STAT_SUM || stat_mode_r == seacc_pkg::STAT_MEAN) begin
      wr_entry.edge_val = sum_sat;
      if (sum_ovf) wr_entry.sat = 1'b1;
      if (stat_mode_r == seacc_pkg::STAT_MEAN) begin
        wr_entry.weight = w_ovf ? {VW{1'b1}} : wsum[VW-1:0];
        if (w_ovf) wr_entry.sat = 1'b1;
      end
    end else if (!rd_r.touched) begin
      wr_entry.edge_val = v_ext;
    end else if (stat_mode_r == seacc_pkg::STAT_MIN) begin
      if (v_ext < $signed(rd_r.edge_val)) wr_entry.edge_val = v_ext;
    end else begin
      if (v_ext > $signed(rd_r.edge_val)) wr_entry.edge_val = v_ext;
    end
  end

  // mean divide
  logic                         e_neg;
  logic [VW-1:0]                e_mag;
  logic [seacc_pkg::DIV_N_W-1:0] div_num, div_q;
  logic                         div_done;
  logic                         need_div;

  assign e_neg    = rd_r.edge_val[VW-1];
  assign e_mag    = e_neg ? (VW'(0) - rd_r.edge_val) : rd_r.edge_val;
  assign div_num  = {e_mag, 16'h0000} + 64'(rd_r.weight >> 1);
  assign need_div = ok_r && rd_r.touched && (stat_mode_r == seacc_pkg::STAT_MEAN) &&
                    (rd_r.weight != '0);

  seacc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (rd_r.weight),
    .quo   (div_q),
    .done  (div_done)
  );

  // finalize the statistic
  logic signed [VW-1:0] q_sat, fin_val;

  always_comb begin
    if (!e_neg) begin
      q_sat = (|div_q[63:VW-1]) ? {1'b0, {(VW-1){1'b1}}} : div_q[VW-1:0];
    end else if ((|div_q[63:VW]) || (div_q[VW-1] && (|div_q[VW-2:0]))) begin
      q_sat = {1'b1, {(VW-1){1'b0}}};
    end else begin
      q_sat = VW'(0) - div_q[VW-1:0];
    end
    if (!ok_r || !rd_r.touched) begin
      fin_val = '0;
    end else if (need_div) begin
      fin_val = q_sat;
    end else begin
      fin_val = rd_r.edge_val;
    end
  end

  // output register
  logic                 out_valid_r;
  logic signed [VW-1:0] out_val_r;
  logic                 out_empty_r, out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_val_r   <= fin_val;
      out_empty_r <= !(ok_r && rd_r.touched);
      out_sat_r   <= ok_r && rd_r.sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_edge_value    = out_val_r;
  assign out_edge_empty    = out_empty_r;
  assign out_sum_saturated = out_sat_r;

  // status to the sequencer
  assign sts.clr_last = (clr_cnt_r == IW'(seacc_pkg::EDGE_DEPTH - 1));
  assign sts.op_read  = (op_r == seacc_pkg::OP_READ);
  assign sts.need_div = need_div;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_en && cmd.wr_en)) else $error("clear and update write collide");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_val_r == '0))
    else $error("empty edge with nonzero value");

  a_empty_nosat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> !out_sat_r)
    else $error("empty edge flagged saturated");

endmodule

// File: rtl/symmetric_edge_statistic_accumulator.sv
`timescale 1ns / 1ps
// Accumulate word: accept in IDLE, table read in READ, table write in EXEC, then back to IDLE for the next word.
// Read word: accept in IDLE, table read in READ, then EXEC, and the result is loaded in OUT once the output
// register is free; a mean read with nonzero weight first runs the bit-serial 64-bit divider in DIV.
// One word in flight at a time; a stalled result word holds off the next input word.
// After reset a clear sweep writes all 8256 table entries, one per cycle;
// no word is accepted during it. Config registers reset to sum, pair mode.
// ----------------------------------------------------------------------------
// symmetric_edge_statistic_accumulator
// Weighted edge statistic table (sum, mean, min, max) with edge read-out.
// ----------------------------------------------------------------------------
module symmetric_edge_statistic_accumulator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [1:0]                          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [seacc_pkg::NODE_W-1:0]        in_node_a,
  input  logic [seacc_pkg::NODE_W-1:0]        in_node_b,
  input  logic signed [31:0]                  in_sample_value,
  input  logic [31:0]                         in_sample_weight,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [seacc_pkg::VAL_W-1:0]  out_edge_value,
  output logic                                out_edge_empty,
  output logic                                out_sum_saturated
);

  seacc_pkg::cmd_t    cmd;
  seacc_pkg::status_t sts;

  seacc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  seacc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_opcode         (in_opcode),
    .in_node_a         (in_node_a),
    .in_node_b         (in_node_b),
    .in_sample_value   (in_sample_value),
    .in_sample_weight  (in_sample_weight),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_edge_value    (out_edge_value),
    .out_edge_empty    (out_edge_empty),
    .out_sum_saturated (out_sum_saturated)
  );

endmodule

// File: sim/seacc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seacc_checker
// Watches the config port and both word channels of the edge statistic
// accumulator. It keeps its own copy of the edge table, predicts each read
// word's statistic, and compares every result word with the oldest prediction.
// ----------------------------------------------------------------------------
module seacc_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [1:0]                    cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [seacc_pkg::NODE_W-1:0]  in_node_a,
  input  logic [seacc_pkg::NODE_W-1:0]  in_node_b,
  input  logic [31:0]                   in_sample_value,
  input  logic [31:0]                   in_sample_weight,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [seacc_pkg::VAL_W-1:0]   out_edge_value,
  input  logic                          out_edge_empty,
  input  logic                          out_sum_saturated,
  output int                            fail_count,
  output int                            pending
);

  localparam longint S48_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint S48_MIN = -64'sh0000_8000_0000_0000;
  localparam longint unsigned U48_MAX = 64'h0000_FFFF_FFFF_FFFF;

  typedef struct {
    logic [seacc_pkg::VAL_W-1:0] value;
    logic                        empty;
    logic                        sat;
  } edge_stat_t;

  // Shadow edge table and config
  longint          edge_acc [seacc_pkg::EDGE_DEPTH];
  longint unsigned edge_wt  [seacc_pkg::EDGE_DEPTH];
  bit              edge_hit [seacc_pkg::EDGE_DEPTH];
  bit              edge_sat [seacc_pkg::EDGE_DEPTH];
  logic [1:0]      cur_stat;
  logic            cur_vec;
  edge_stat_t      stat_queue[$];

  function automatic longint clamp48(longint v, ref bit hit);
    if (v > S48_MAX) begin
      hit = 1'b1;
      return S48_MAX;
    end
    if (v < S48_MIN) begin
      hit = 1'b1;
      return S48_MIN;
    end
    return v;
  endfunction

  function automatic int unsigned edge_slot(logic [seacc_pkg::NODE_W-1:0] a,
                                            logic [seacc_pkg::NODE_W-1:0] b);
    int unsigned lo, hi;
    if (cur_vec) return b;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return lo * (2 * seacc_pkg::NODE_COUNT + 1 - lo) / 2 + (hi - lo);
  endfunction

  // Fold one streamline sample into the shadow table
  task automatic fold_sample(int unsigned idx, logic [31:0] v, logic [31:0] w);
    bit              neg, hit;
    longint unsigned mag, r, t;
    longint          sv, term;
    neg = v[31];
    hit = 1'b0;
    mag = neg ? (64'h1_0000_0000 - {32'b0, v}) : {32'b0, v};
    sv  = neg ? -longint'(mag) : longint'(mag);
    if (cur_stat == seacc_pkg::STAT_SUM || cur_stat == seacc_pkg::STAT_MEAN) begin
      r    = (mag * {32'b0, w} + 64'h8000) >> 16;
      term = neg ? -longint'(r) : longint'(r);
      edge_acc[idx] = clamp48(edge_acc[idx] + term, hit);
      if (cur_stat == seacc_pkg::STAT_MEAN) begin
        t = edge_wt[idx] + {32'b0, w};
        if (t > U48_MAX) begin
          t   = U48_MAX;
          hit = 1'b1;
        end
        edge_wt[idx] = t;
      end
    end else if (!edge_hit[idx]) begin
      edge_acc[idx] = sv;
    end else if (cur_stat == seacc_pkg::STAT_MIN) begin
      if (sv < edge_acc[idx]) edge_acc[idx] = sv;
    end else begin
      if (sv > edge_acc[idx]) edge_acc[idx] = sv;
    end
    edge_hit[idx] = 1'b1;
    if (hit) edge_sat[idx] = 1'b1;
  endtask

  // Finalized statistic of one edge
  function automatic longint edge_result(int unsigned idx);
    longint          s;
    longint unsigned w, mag, q;
    bit              neg, dummy;
    s = edge_acc[idx];
    w = edge_wt[idx];
    dummy = 1'b0;
    if (!edge_hit[idx]) return 0;
    if (cur_stat != seacc_pkg::STAT_MEAN || w == 0) return s;
    neg = s < 0;
    mag = neg ? longint'(-s) : longint'(s);
    q = ((mag << 16) + w / 2) / w;
    if (q > (64'd1 << 48)) q = 64'd1 << 48;
    return clamp48(neg ? -longint'(q) : longint'(q), dummy);
  endfunction

  always @(posedge clk) begin
    edge_stat_t  want, got;
    int unsigned idx;
    longint      val;
    if (!rst_n) begin
      fail_count = 0;
      pending    = 0;
      cur_stat   = seacc_pkg::STAT_SUM;
      cur_vec    = 1'b0;
    end else begin
      // Track register writes
      if (cfg_we) begin
        if (cfg_index == seacc_pkg::REG_STAT_MODE) cur_stat = cfg_wdata;
        if (cfg_index == seacc_pkg::REG_VECTOR_MODE) cur_vec = cfg_wdata[0];
      end
      // Predict on accepted input word
      if (in_valid && in_ready) begin
        idx = edge_slot(in_node_a, in_node_b);
        if (in_opcode == seacc_pkg::OP_ACC) begin
          fold_sample(idx, in_sample_value, in_sample_weight);
        end else begin
          val        = edge_result(idx);
          want.value = val[seacc_pkg::VAL_W-1:0];
          want.empty = !edge_hit[idx];
          want.sat   = edge_sat[idx];
          stat_queue.insert(stat_queue.size(), want);
        end
      end
      // Compare accepted result word
      if (out_valid && out_ready) begin
        got.value = out_edge_value;
        got.empty = out_edge_empty;
        got.sat   = out_sum_saturated;
        if (stat_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result word: value=%h empty=%b sat=%b",
                     got.value, got.empty, got.sat);
        end else begin
          want = stat_queue.pop_front();
          if (got.value !== want.value || got.empty !== want.empty ||
              got.sat !== want.sat) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: exp value=%h empty=%b sat=%b, got value=%h empty=%b sat=%b",
                       want.value, want.empty, want.sat, got.value, got.empty, got.sat);
          end
        end
      end
      pending = stat_queue.size();
    end
  end

endmodule

// File: sim/tb_symmetric_edge_statistic_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_symmetric_edge_statistic_accumulator
// Drives accumulate and read words through several stat/vector mode settings,
// with bursty input and stalling output; the checker module grades results.
// ----------------------------------------------------------------------------
module tb_symmetric_edge_statistic_accumulator;

  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [1:0]                         cfg_index = '0;
  logic [1:0]                         cfg_wdata = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               in_opcode = seacc_pkg::OP_ACC;
  logic [seacc_pkg::NODE_W-1:0]       in_node_a = '0;
  logic [seacc_pkg::NODE_W-1:0]       in_node_b = '0;
  logic signed [31:0]                 in_sample_value = '0;
  logic [31:0]                        in_sample_weight = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic signed [seacc_pkg::VAL_W-1:0] out_edge_value;
  logic                               out_edge_empty;
  logic                               out_sum_saturated;
  int                                 fail_count;
  int                                 pending;
  int                                 cycles = 0;
  int                                 burst_left = 0;
  int                                 stall_style = 0;

  always #5 clk = ~clk;

  symmetric_edge_statistic_accumulator dut (.*);

  seacc_checker u_checker (.*);

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stall pattern: the style is redrawn at random as the run goes on
  always @(posedge clk) begin
    if (cycles % 256 == 0) stall_style <= $urandom_range(0, 2);
    case (stall_style)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) == 0);
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic write_reg(logic [1:0] idx, logic [1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Drop valid, drain expected results, then let trailing accumulates retire
  task automatic drain();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Send one word; hold valid into the next word inside a burst
  task automatic send_word(logic op, logic [6:0] a, logic [6:0] b,
                           logic [31:0] v, logic [31:0] w);
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_node_a        <= a;
    in_node_b        <= b;
    in_sample_value  <= v;
    in_sample_weight <= w;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(0, 12);
      repeat ($urandom_range(0, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom_range(0, 32'h0003_0000);
      5:       return -$urandom_range(0, 32'h0003_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h0001_0000;
      3:       return $urandom_range(1, 16);
      4:       return $urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  // Random words: mostly a few hot nodes so edges get revisited
  task automatic random_words(int count);
    logic [6:0] a, b;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 3) != 0) begin
        a = $urandom_range(0, 5);
        b = $urandom_range(0, 5);
      end else begin
        a = $urandom_range(0, 127);
        b = $urandom_range(0, 127);
      end
      send_word(($urandom_range(0, 9) < 3) ? seacc_pkg::OP_READ : seacc_pkg::OP_ACC,
                a, b, pick_value(), pick_weight());
    end
  endtask

  initial begin
    logic [1:0] stat_seq [8] = '{seacc_pkg::STAT_SUM, seacc_pkg::STAT_MEAN,
                                 seacc_pkg::STAT_MIN, seacc_pkg::STAT_MAX,
                                 seacc_pkg::STAT_MEAN, seacc_pkg::STAT_MAX,
                                 seacc_pkg::STAT_MIN, seacc_pkg::STAT_SUM};
    logic       vec_seq  [8] = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: untouched edge, sum saturation, swapped pair, corner nodes
    write_reg(seacc_pkg::REG_STAT_MODE, seacc_pkg::STAT_SUM);
    write_reg(seacc_pkg::REG_VECTOR_MODE, 1'b0);
    write_reg(REG_SPARE, 2'd3);
    send_word(seacc_pkg::OP_READ, 7'd3, 7'd5, '0, '0);
    send_word(seacc_pkg::OP_ACC, 7'd3, 7'd5, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(seacc_pkg::OP_ACC, 7'd5, 7'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_word(seacc_pkg::OP_READ, 7'd5, 7'd3, '0, '0);
    send_word(seacc_pkg::OP_ACC, 7'd0, 7'd0, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(seacc_pkg::OP_ACC, 7'd0, 7'd0, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(seacc_pkg::OP_READ, 7'd0, 7'd0, '0, '0);
    send_word(seacc_pkg::OP_ACC, 7'd127, 7'd127, 32'h0000_0001, 32'h0000_0000);
    send_word(seacc_pkg::OP_READ, 7'd127, 7'd127, '0, '0);
    send_word(seacc_pkg::OP_ACC, 7'd0, 7'd127, 32'hFFFF_FFFF, 32'h0000_8000);
    send_word(seacc_pkg::OP_READ, 7'd127, 7'd0, '0, '0);
    drain();

    // Directed: mean with zero weight total, tiny weight, min/max first sample
    write_reg(seacc_pkg::REG_STAT_MODE, seacc_pkg::STAT_MEAN);
    send_word(seacc_pkg::OP_READ, 7'd3, 7'd5, '0, '0);
    send_word(seacc_pkg::OP_ACC, 7'd1, 7'd2, 32'h8000_0000, 32'h0000_0001);
    send_word(seacc_pkg::OP_ACC, 7'd1, 7'd2, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(seacc_pkg::OP_READ, 7'd2, 7'd1, '0, '0);
    send_word(seacc_pkg::OP_ACC, 7'd9, 7'd9, 32'h7FFF_FFFF, 32'h0000_0001);
    send_word(seacc_pkg::OP_READ, 7'd9, 7'd9, '0, '0);
    drain();
    write_reg(seacc_pkg::REG_STAT_MODE, seacc_pkg::STAT_MIN);
    send_word(seacc_pkg::OP_ACC, 7'd20, 7'd21, 32'h7FFF_FFFF, '0);
    send_word(seacc_pkg::OP_ACC, 7'd21, 7'd20, 32'h8000_0000, '0);
    send_word(seacc_pkg::OP_READ, 7'd20, 7'd21, '0, '0);
    drain();
    write_reg(seacc_pkg::REG_STAT_MODE, seacc_pkg::STAT_MAX);
    send_word(seacc_pkg::OP_ACC, 7'd30, 7'd31, 32'h8000_0000, '0);
    send_word(seacc_pkg::OP_READ, 7'd30, 7'd31, '0, '0);
    drain();

    // Random phases over mode settings
    for (int p = 0; p < 8; p++) begin
      write_reg(seacc_pkg::REG_STAT_MODE, stat_seq[p]);
      write_reg(seacc_pkg::REG_VECTOR_MODE, vec_seq[p]);
      random_words(240);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
